// ----- rtl/ocu_pkg.sv -----
// Shared types, constants and arithmetic helpers for the orbit camera block.
// No dependencies; every other file refers to this package by scoped names.
package ocu_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int CNT_W        = 5;

  localparam int FULL_TURN    = 360 << FRAC_BITS;
  localparam int HALF_TURN    = 180 << FRAC_BITS;
  localparam int QUARTER_TURN = 90 << FRAC_BITS;

  localparam int ANG_W = 18;
  localparam int Z_W   = 26;
  localparam int XY_W  = 33;
  localparam int PROD_W = 2 * XY_W;

  localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(652032875);

  localparam logic [14:0] PITCH_LIMIT_RST = 15'(89 << FRAC_BITS);
  localparam logic [16:0] MIN_DIST_RST    = 17'(2 << FRAC_BITS);
  localparam logic [16:0] MAX_DIST_RST    = 17'(500 << FRAC_BITS);
  localparam logic [16:0] DIST_RST        = 17'(35 << FRAC_BITS);
  localparam logic [16:0] YAW_RST         = 17'(35 << FRAC_BITS);
  localparam logic signed [15:0] PITCH_RST = 16'(25 << FRAC_BITS);
  localparam logic signed [23:0] TGT_Y_RST = 24'(2 << FRAC_BITS);

  localparam logic [1:0] REG_PITCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_DIST    = 2'd1;
  localparam logic [1:0] REG_MAX_DIST    = 2'd2;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [16:0]        yaw;
    logic signed [15:0] pitch;
    logic [16:0]        orbit_dist;
    logic signed [17:0] pan_right;
    logic signed [17:0] pan_up;
  } q_item_t;

  // Arctangent of 2^-i in degrees with 16 fraction bits.
  function automatic logic [22:0] atan_deg16(input logic [CNT_W-1:0] i);
    logic [22:0] r;
    case (i)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117304;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      5'd20: r = 23'd4;
      5'd21: r = 23'd2;
      5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // Drop 30 fraction bits, rounding to nearest with ties toward plus infinity.
  function automatic logic signed [35:0] rnd30(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + (PROD_W'(1) <<< 29);
    return t[65:30];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
    logic signed [23:0] r;
    if (v > 38'sd8388607) r = 24'sd8388607;
    else if (v < -38'sd8388608) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ----- rtl/ocu_front.sv -----
// Front end: configuration registers, orbit and zoom state update per beat.
// Depends on ocu_pkg; hands the updated angles and pans to the queue.
module ocu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_wdata,
  input  logic                 take,
  input  logic signed [15:0]   delta_yaw,
  input  logic signed [15:0]   delta_pitch,
  input  logic signed [17:0]   delta_distance,
  input  logic signed [17:0]   pan_right,
  input  logic signed [17:0]   pan_up,
  output ocu_pkg::q_item_t     item
);

  logic [14:0]        pitch_limit_r;
  logic [16:0]        min_dist_r, max_dist_r;
  logic [16:0]        yaw_r, yaw_nxt;
  logic signed [15:0] pitch_r, pitch_nxt;
  logic [16:0]        dist_r, dist_nxt;

  logic signed [18:0] ys;
  logic signed [16:0] ps, lim;
  logic signed [18:0] ds;

  always_comb begin
    ys = $signed({2'b00, yaw_r}) + 19'(delta_yaw);
    if (ys < 19'sd0) ys = ys + 19'(ocu_pkg::FULL_TURN);
    else if (ys >= 19'(ocu_pkg::FULL_TURN)) ys = ys - 19'(ocu_pkg::FULL_TURN);
    yaw_nxt = ys[16:0];

    lim = $signed({2'b00, pitch_limit_r});
    ps  = 17'(pitch_r) + 17'(delta_pitch);
    if (ps < -lim) ps = -lim;
    else if (ps > lim) ps = lim;
    pitch_nxt = ps[15:0];

    // Min is checked first; if the limits cross, max wins at or above min.
    ds = $signed({2'b00, dist_r}) + 19'(delta_distance);
    if (ds < $signed({2'b00, min_dist_r})) ds = $signed({2'b00, min_dist_r});
    else if (ds > $signed({2'b00, max_dist_r})) ds = $signed({2'b00, max_dist_r});
    dist_nxt = ds[16:0];
  end

  assign item.yaw        = yaw_nxt;
  assign item.pitch      = pitch_nxt;
  assign item.orbit_dist = dist_nxt;
  assign item.pan_right  = pan_right;
  assign item.pan_up     = pan_up;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_limit_r <= ocu_pkg::PITCH_LIMIT_RST;
      min_dist_r    <= ocu_pkg::MIN_DIST_RST;
      max_dist_r    <= ocu_pkg::MAX_DIST_RST;
      yaw_r         <= ocu_pkg::YAW_RST;
      pitch_r       <= ocu_pkg::PITCH_RST;
      dist_r        <= ocu_pkg::DIST_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ocu_pkg::REG_PITCH_LIMIT: pitch_limit_r <= cfg_wdata[14:0];
          ocu_pkg::REG_MIN_DIST:    min_dist_r    <= cfg_wdata;
          ocu_pkg::REG_MAX_DIST:    max_dist_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        yaw_r   <= yaw_nxt;
        pitch_r <= pitch_nxt;
        dist_r  <= dist_nxt;
      end
    end
  end

endmodule

// ----- rtl/ocu_fifo.sv -----
// Short queue between the front end and the back end.
// Depends on ocu_pkg for the item type and depth.
module ocu_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ocu_pkg::q_item_t wdata,
  input  logic             pop,
  output ocu_pkg::q_item_t rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (ocu_pkg::QDEPTH > 1) ? $clog2(ocu_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(ocu_pkg::QDEPTH + 1);

  ocu_pkg::q_item_t mem_r [ocu_pkg::QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(ocu_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(ocu_pkg::QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop)  rp_r <= inc(rp_r);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ----- rtl/ocu_cordic.sv -----
// Iterative rotation CORDIC, one micro-rotation per cycle, sine and cosine in Q30.
// Depends on ocu_pkg for the arctangent table and widths.
module ocu_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ocu_pkg::ANG_W-1:0]    angle,
  output logic                                done,
  output logic signed [ocu_pkg::XY_W-1:0]     sin_q,
  output logic signed [ocu_pkg::XY_W-1:0]     cos_q
);

  localparam logic signed [ocu_pkg::ANG_W-1:0] QTR  = ocu_pkg::ANG_W'(ocu_pkg::QUARTER_TURN);
  localparam logic signed [ocu_pkg::ANG_W-1:0] HALF = ocu_pkg::ANG_W'(ocu_pkg::HALF_TURN);

  logic signed [ocu_pkg::XY_W-1:0] x_r, y_r;
  logic signed [ocu_pkg::Z_W-1:0]  z_r, at_s;
  logic [ocu_pkg::CNT_W-1:0]       cnt_r;
  logic                            busy_r, done_r, flip_r;
  logic signed [ocu_pkg::ANG_W-1:0] fa;
  logic                             ff;

  // The angle arrives in (-180, 180] degrees; fold it into the convergence range.
  always_comb begin
    fa = angle;
    ff = 1'b0;
    if (angle > QTR) begin
      fa = angle - HALF;
      ff = 1'b1;
    end else if (angle < -QTR) begin
      fa = angle + HALF;
      ff = 1'b1;
    end
  end

  assign at_s  = signed'(ocu_pkg::Z_W'(ocu_pkg::atan_deg16(cnt_r)));
  assign done  = done_r;
  assign sin_q = flip_r ? -y_r : y_r;
  assign cos_q = flip_r ? -x_r : x_r;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= ocu_pkg::INV_GAIN;
      y_r    <= '0;
      z_r    <= ocu_pkg::Z_W'(fa) <<< (16 - ocu_pkg::FRAC_BITS);
      flip_r <= ff;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - (y_r >>> cnt_r);
        y_r <= y_r + (x_r >>> cnt_r);
        z_r <= z_r - at_s;
      end else begin
        x_r <= x_r + (y_r >>> cnt_r);
        y_r <= y_r - (x_r >>> cnt_r);
        z_r <= z_r + at_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + ocu_pkg::CNT_W'(1);
        if (cnt_r == ocu_pkg::CNT_W'(ocu_pkg::CORDIC_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ocu_back.sv -----
// Back end: sequences two CORDIC passes and eight slots of one shared multiplier,
// keeps the target point and drives the result register. Depends on ocu_pkg, ocu_cordic.
module ocu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ocu_pkg::q_item_t    q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_eye_x,
  output logic signed [23:0]  out_eye_y,
  output logic signed [23:0]  out_eye_z
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_YAW   = 5'b00010,
    S_PITCH = 5'b00100,
    S_MUL   = 5'b01000,
    S_DONE  = 5'b10000
  } bstate_t;

  localparam int XW = ocu_pkg::XY_W;

  bstate_t state_r, state_nxt;
  ocu_pkg::q_item_t item_r;
  logic [2:0] m_r;

  logic                          c_start, c_done;
  logic signed [ocu_pkg::ANG_W-1:0] c_ang, yaw_s;
  logic signed [XW-1:0]          c_sin, c_cos;
  logic signed [XW-1:0]          sy_r, cy_r, sp_r, cp_r, fx_r, fz_r;
  logic signed [XW-1:0]          ma, mb, dist_s, pr_s;
  logic signed [ocu_pkg::PROD_W-1:0] prod_r;
  logic signed [35:0]            rnd;
  logic signed [23:0]            tx_r, ty_r, tz_r, ex_r, ey_r, ez_r;
  logic                          out_valid_r;
  logic                          out_load;

  // Yaw is kept in [0, 360); move it into (-180, 180] for the CORDIC.
  always_comb begin
    yaw_s = signed'({1'b0, q_head.yaw});
    if (yaw_s > ocu_pkg::ANG_W'(ocu_pkg::HALF_TURN))
      yaw_s = yaw_s - ocu_pkg::ANG_W'(ocu_pkg::FULL_TURN);
  end

  assign q_pop   = (state_r == S_IDLE) && !q_empty;
  assign c_start = q_pop || ((state_r == S_YAW) && c_done);
  assign c_ang   = (state_r == S_IDLE) ? yaw_s : ocu_pkg::ANG_W'(item_r.pitch);

  ocu_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_start),
    .angle (c_ang),
    .done  (c_done),
    .sin_q (c_sin),
    .cos_q (c_cos)
  );

  assign dist_s = signed'(XW'(item_r.orbit_dist));
  assign pr_s   = XW'(item_r.pan_right);

  always_comb begin
    case (m_r)
      3'd0:    begin ma = cy_r;   mb = pr_s; end
      3'd1:    begin ma = sy_r;   mb = pr_s; end
      3'd2:    begin ma = cp_r;   mb = sy_r; end
      3'd3:    begin ma = cp_r;   mb = cy_r; end
      3'd4:    begin ma = dist_s; mb = sp_r; end
      3'd5:    begin ma = dist_s; mb = fx_r; end
      3'd6:    begin ma = dist_s; mb = fz_r; end
      default: begin ma = '0;     mb = '0;   end
    endcase
  end

  assign rnd      = ocu_pkg::rnd30(prod_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_YAW;
      S_YAW:   if (c_done) state_nxt = S_PITCH;
      S_PITCH: if (c_done) state_nxt = S_MUL;
      S_MUL:   if (m_r == 3'd7) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Each product is consumed in the slot after it was issued.
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_head;
    if (state_r == S_YAW && c_done) begin
      sy_r <= c_sin;
      cy_r <= c_cos;
    end
    if (state_r == S_PITCH && c_done) begin
      sp_r <= c_sin;
      cp_r <= c_cos;
    end
    prod_r <= ma * mb;
    if (state_r == S_MUL) begin
      case (m_r)
        3'd1: tx_r <= ocu_pkg::sat24(38'(tx_r) + 38'(rnd));
        3'd2: tz_r <= ocu_pkg::sat24(38'(tz_r) - 38'(rnd));
        3'd3: fx_r <= rnd[XW-1:0];
        3'd4: fz_r <= rnd[XW-1:0];
        3'd5: ey_r <= ocu_pkg::sat24(38'(ty_r) + 38'(rnd));
        3'd6: ex_r <= ocu_pkg::sat24(38'(tx_r) + 38'(rnd));
        3'd7: ez_r <= ocu_pkg::sat24(38'(tz_r) + 38'(rnd));
        default: ;
      endcase
    end
    if (out_load) begin
      out_eye_x <= ex_r;
      out_eye_y <= ey_r;
      out_eye_z <= ez_r;
    end
    if (!rst_n) begin
      tx_r <= '0;
      tz_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      m_r         <= '0;
      out_valid_r <= 1'b0;
      ty_r        <= ocu_pkg::TGT_Y_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MUL) m_r <= m_r + 3'd1;
      else m_r <= '0;
      if (state_r == S_MUL && m_r == 3'd0)
        ty_r <= ocu_pkg::sat24(38'(ty_r) + 38'(item_r.pan_up));
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("back state not one-hot");

  a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    c_done |-> (state_r == S_YAW || state_r == S_PITCH))
    else $error("CORDIC finished outside a pass");

  a_mul_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && m_r == 3'd7) |=> (state_r == S_DONE))
    else $error("multiply sequence did not end in DONE");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_YAW)) else $error("pop did not start a yaw pass");

endmodule

// ----- rtl/orbit_camera_update.sv -----
// Top level of the orbit camera block: front end, queue and back end.
// Depends on ocu_pkg, ocu_front, ocu_fifo and ocu_back.
//
// Each accepted input beat updates yaw, pitch and distance, pans the target and
// returns one eye position beat. An item that leaves the queue goes through two
// 16-step CORDIC passes in one shared iteration unit, yaw first and then pitch,
// eight slots of one shared multiplier and the hand-off to the result register.
// The back end passes through idle before it pops the next item, so it takes no
// new item before it is through with the last one. The front end takes up to two
// further beats into its queue while the back end works, and the result register
// lets a new item start while the previous result waits.
// Configuration writes take effect at once and are meant for an idle block.
module orbit_camera_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_delta_yaw,
  input  logic signed [15:0] in_delta_pitch,
  input  logic signed [17:0] in_delta_distance,
  input  logic signed [17:0] in_pan_right,
  input  logic signed [17:0] in_pan_up,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_eye_x,
  output logic signed [23:0] out_eye_y,
  output logic signed [23:0] out_eye_z
);

  ocu_pkg::q_item_t f_item, q_head;
  logic take, q_full, q_empty, q_pop;

  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;

  ocu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .take           (take),
    .delta_yaw      (in_delta_yaw),
    .delta_pitch    (in_delta_pitch),
    .delta_distance (in_delta_distance),
    .pan_right      (in_pan_right),
    .pan_up         (in_pan_up),
    .item           (f_item)
  );

  ocu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .wdata (f_item),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  ocu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_eye_x (out_eye_x),
    .out_eye_y (out_eye_y),
    .out_eye_z (out_eye_z)
  );

endmodule

// ----- tb/tb_orbit_camera_update.sv -----
// Self-checking testbench for orbit_camera_update: directed table, then random beats.
// Depends on ocu_pkg and the orbit_camera_update RTL; predicts eye positions in-line.
`timescale 1ns / 1ps

module tb_orbit_camera_update;

  typedef struct {
    logic signed [15:0] dyaw;
    logic signed [15:0] dpitch;
    logic signed [17:0] ddist;
    logic signed [17:0] pan_r;
    logic signed [17:0] pan_u;
    logic               known;
    logic signed [23:0] ex, ey, ez;
  } stim_row_t;

  typedef struct {
    logic signed [23:0] ex, ey, ez;
  } eye_t;

  localparam int NUM_RANDOM = 1330;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [16:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_delta_yaw = '0;
  logic signed [15:0] in_delta_pitch = '0;
  logic signed [17:0] in_delta_distance = '0;
  logic signed [17:0] in_pan_right = '0;
  logic signed [17:0] in_pan_up = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] out_eye_x, out_eye_y, out_eye_z;

  orbit_camera_update dut (.*);

  always #1 clk = ~clk;

  // Predictor state and registers.
  longint cam_tx, cam_ty, cam_tz, cam_dist, cam_yaw, cam_pitch;
  longint lim_pitch, lim_min, lim_max;
  eye_t   eye_q[$];
  int     errors = 0;
  bit     stim_done = 0;
  bit     hold_off = 0;
  int     beats_out = 0;

  const longint ATAN_TBL[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 8388607;
    if (v < -64'sd8388608) return -8388608;
    return v;
  endfunction

  function automatic longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic cordic_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit     flip;
    x = 652032875;
    y = 0;
    flip = 0;
    ang = ang % ocu_pkg::FULL_TURN;
    if (ang < 0) ang += ocu_pkg::FULL_TURN;
    if (ang > ocu_pkg::HALF_TURN) ang -= ocu_pkg::FULL_TURN;
    if (ang > ocu_pkg::QUARTER_TURN) begin
      ang -= ocu_pkg::HALF_TURN;
      flip = 1;
    end else if (ang < -ocu_pkg::QUARTER_TURN) begin
      ang += ocu_pkg::HALF_TURN;
      flip = 1;
    end
    z = ang <<< (16 - ocu_pkg::FRAC_BITS);
    for (int i = 0; i < ocu_pkg::CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= ATAN_TBL[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += ATAN_TBL[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic camera_reset();
    cam_tx = 0;
    cam_ty = 512;
    cam_tz = 0;
    cam_dist = 8960;
    cam_yaw = 8960;
    cam_pitch = 6400;
    lim_pitch = 22784;
    lim_min = 512;
    lim_max = 128000;
  endtask

  task automatic predict_eye(input stim_row_t r, output eye_t e);
    longint sy, cy, sp, cp, p, d;
    cam_yaw = (cam_yaw + longint'(r.dyaw)) % ocu_pkg::FULL_TURN;
    if (cam_yaw < 0) cam_yaw += ocu_pkg::FULL_TURN;
    p = cam_pitch + longint'(r.dpitch);
    if (p < -lim_pitch) p = -lim_pitch;
    else if (p > lim_pitch) p = lim_pitch;
    cam_pitch = p;
    d = cam_dist + longint'(r.ddist);
    if (d < lim_min) d = lim_min;
    else if (d > lim_max) d = lim_max;
    cam_dist = d;
    cordic_sincos(cam_yaw, sy, cy);
    cam_tx = clamp24(cam_tx + round_q30(cy * longint'(r.pan_r)));
    cam_tz = clamp24(cam_tz - round_q30(sy * longint'(r.pan_r)));
    cam_ty = clamp24(cam_ty + longint'(r.pan_u));
    cordic_sincos(cam_pitch, sp, cp);
    e.ex = 24'(clamp24(cam_tx + round_q30(cam_dist * round_q30(cp * sy))));
    e.ey = 24'(clamp24(cam_ty + round_q30(cam_dist * sp)));
    e.ez = 24'(clamp24(cam_tz + round_q30(cam_dist * round_q30(cp * cy))));
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ocu_pkg::REG_PITCH_LIMIT: lim_pitch = val[14:0];
      ocu_pkg::REG_MIN_DIST:    lim_min = val;
      ocu_pkg::REG_MAX_DIST:    lim_max = val;
      default: ;
    endcase
  endtask

  // Sends one beat; called right after a falling edge. Valid stays high into the
  // next beat when no idle cycles are drawn; drain_wait drops it after a batch.
  task automatic send_beat(input stim_row_t r);
    eye_t e;
    int   idle;
    idle = $urandom_range(0, 3);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_delta_yaw <= r.dyaw;
    in_delta_pitch <= r.dpitch;
    in_delta_distance <= r.ddist;
    in_pan_right <= r.pan_r;
    in_pan_up <= r.pan_u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_eye(r, e);
    if (r.known) begin
      e.ex = r.ex;
      e.ey = r.ey;
      e.ez = r.ez;
    end
    eye_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (eye_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic stim_row_t rand_row(bit well_formed);
    stim_row_t r;
    r.known = 0;
    r.ex = '0; r.ey = '0; r.ez = '0;
    r.dyaw = 16'($urandom);
    r.dpitch = 16'($urandom);
    r.ddist = 18'($urandom);
    r.pan_r = 18'($urandom);
    r.pan_u = 18'($urandom);
    if (well_formed) begin
      // Mostly small motions so the camera stays inside its limits.
      r.dpitch = 16'($signed($urandom_range(0, 2047)) - 1024);
      r.ddist = 18'($signed($urandom_range(0, 4095)) - 2048);
      r.pan_r = 18'($signed($urandom_range(0, 8191)) - 4096);
      r.pan_u = 18'($signed($urandom_range(0, 8191)) - 4096);
    end
    return r;
  endfunction

  function automatic stim_row_t row(int dy, int dp, int dd, int pr, int pu);
    stim_row_t r;
    r.dyaw = 16'(dy); r.dpitch = 16'(dp); r.ddist = 18'(dd);
    r.pan_r = 18'(pr); r.pan_u = 18'(pu);
    r.known = 0; r.ex = '0; r.ey = '0; r.ez = '0;
    return r;
  endfunction

  // Receiver: a random wait before each beat, plus one long hold-off on request.
  initial begin
    int idle;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end else begin
        idle = $urandom_range(0, 3);
        if (idle != 0) begin
          out_ready <= 1'b0;
          repeat (idle) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    eye_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (eye_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        e = eye_q.pop_front();
        if (out_eye_x !== e.ex) report_mismatch("eye_x", out_eye_x, e.ex);
        if (out_eye_y !== e.ey) report_mismatch("eye_y", out_eye_y, e.ey);
        if (out_eye_z !== e.ez) report_mismatch("eye_z", out_eye_z, e.ez);
      end
    end
  end

  initial begin
    stim_row_t dir_tbl[$];
    stim_row_t r;
    camera_reset();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero motion after reset: eye sits at the default orbit.
    dir_tbl.push_back(row(0, 0, 0, 0, 0));
    dir_tbl.push_back(row(32767, 32767, 131071, 131071, 131071));
    dir_tbl.push_back(row(-32768, -32768, -131072, -131072, -131072));
    dir_tbl.push_back(row(23040, 0, 0, 0, 0));       // yaw steps up by 90 degrees
    dir_tbl.push_back(row(-23040, 0, 0, 0, 0));      // yaw steps back by 90 degrees
    dir_tbl.push_back(row(0, 30000, 0, 0, 0));       // large pitch step upward
    dir_tbl.push_back(row(0, -30000, 0, 0, 0));      // large pitch step downward
    dir_tbl.push_back(row(0, 0, -131072, 0, 0));     // distance clamps at min
    dir_tbl.push_back(row(0, 0, 131071, 0, 0));      // distance clamps at max
    for (int i = 0; i < 8; i++) dir_tbl.push_back(row(0, 0, 0, 131071, 131071));
    for (int i = 0; i < 8; i++) dir_tbl.push_back(row(11520, 0, 0, -131072, -131072));
    foreach (dir_tbl[i]) send_beat(dir_tbl[i]);
    drain_wait();

    // Pitch limit above a right angle and min above max.
    write_reg(ocu_pkg::REG_PITCH_LIMIT, 17'd32767);
    write_reg(ocu_pkg::REG_MIN_DIST, 17'd128000);
    write_reg(ocu_pkg::REG_MAX_DIST, 17'd0);
    write_reg(2'd3, 17'h1FFFF);
    for (int i = 0; i < 6; i++) send_beat(rand_row(0));
    drain_wait();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(ocu_pkg::REG_PITCH_LIMIT, 17'd0);
          write_reg(ocu_pkg::REG_MIN_DIST, 17'd0);
          write_reg(ocu_pkg::REG_MAX_DIST, 17'd131071);
        end
        1: begin
          write_reg(ocu_pkg::REG_PITCH_LIMIT, 17'd23040);
          write_reg(ocu_pkg::REG_MIN_DIST, 17'd512);
          write_reg(ocu_pkg::REG_MAX_DIST, 17'd128000);
        end
        2: begin
          write_reg(ocu_pkg::REG_PITCH_LIMIT, 17'($urandom_range(0, 23040)));
          write_reg(ocu_pkg::REG_MIN_DIST, 17'($urandom_range(0, 4000)));
          write_reg(ocu_pkg::REG_MAX_DIST, 17'($urandom_range(20000, 128000)));
        end
        default: begin
          write_reg(ocu_pkg::REG_PITCH_LIMIT, 17'd22784);
          write_reg(ocu_pkg::REG_MIN_DIST, 17'd512);
          write_reg(ocu_pkg::REG_MAX_DIST, 17'd128000);
        end
      endcase
      for (int i = 0; i < NUM_RANDOM / 4; i++) begin
        if (ph == 1 && i == 20) hold_off = 1;
        send_beat(rand_row($urandom_range(0, 9) < 8));
      end
      drain_wait();
    end
    stim_done = 1;
    if (errors == 0 && eye_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #600000;
    $display("FAIL");
    $finish;
  end

endmodule
